### src/ndhs_pkg.sv
// Shared constants and types for the node dedup hash store.
`default_nettype none
package ndhs_pkg;
  localparam int TABLE_SIZE    = 4093;
  localparam int TBL_AW        = 12;
  localparam int NODE_EDGE_CAP = 256;
  localparam int CNT_W         = 9;
  localparam int IDX_W         = 8;
  localparam int EDGE_W        = 32;
  localparam int HASH_W        = 32;
  localparam int FIRST_STEP    = 9;
  localparam int STEP_GROWTH   = 8;
  localparam int START_RESET   = 256;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_STORE_FULL = 2'd2;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [CNT_W-1:0]  count;
    logic              bank;
  } job_t;

  typedef struct packed {
    logic              we;
    logic              bank;
    logic [IDX_W-1:0]  idx;
    logic [EDGE_W-1:0] data;
  } buf_wr_t;
endpackage
`default_nettype wire

### src/ndhs_front.sv
// Front end: accepts edge requests, folds the hash and fills the edge buffer.
`default_nettype none
module ndhs_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [ndhs_pkg::EDGE_W-1:0] edge_word,
  input  wire logic                       last_edge,
  output ndhs_pkg::buf_wr_t               buf_wr,
  output logic                            push,
  output ndhs_pkg::job_t                  job
);
  logic [ndhs_pkg::HASH_W-1:0] hash_r, hash_nxt;
  logic [ndhs_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        bank_r;
  logic                        keep;
  logic [ndhs_pkg::HASH_W-1:0] folded;

  assign keep   = accept && (count_r < ndhs_pkg::CNT_W'(ndhs_pkg::NODE_EDGE_CAP));
  assign folded = {hash_r[ndhs_pkg::HASH_W-2:0], hash_r[ndhs_pkg::HASH_W-1]} ^ edge_word;

  always_comb begin
    hash_nxt  = keep ? folded : hash_r;
    count_nxt = keep ? count_r + 1'b1 : count_r;
  end

  assign buf_wr.we   = keep;
  assign buf_wr.bank = bank_r;
  assign buf_wr.idx  = count_r[ndhs_pkg::IDX_W-1:0];
  assign buf_wr.data = edge_word;

  assign push       = accept && last_edge;
  assign job.hash   = hash_nxt;
  assign job.count  = count_nxt;
  assign job.bank   = bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= '0;
      count_r <= '0;
      bank_r  <= 1'b0;
    end else if (push) begin
      hash_r  <= '0;
      count_r <= '0;
      bank_r  <= ~bank_r;
    end else begin
      hash_r  <= hash_nxt;
      count_r <= count_nxt;
    end
  end
endmodule
`default_nettype wire

### src/ndhs_queue.sv
// Two-entry queue of closed nodes between the front and back ends.
`default_nettype none
module ndhs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ndhs_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                head_valid,
  output ndhs_pkg::job_t      head_job,
  output logic                full
);
  ndhs_pkg::job_t slot_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign head_valid = (cnt_r != 2'd0);
  assign full       = (cnt_r == 2'd2);
  assign head_job   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### src/ndhs_back.sv
// Back end: hash reduction, quadratic probing, node compare and append.
`default_nettype none
module ndhs_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ndhs_pkg::buf_wr_t           buf_wr,
  input  wire logic                        job_valid,
  input  wire ndhs_pkg::job_t              job,
  output logic                             pop,
  output logic                             clearing,
  input  wire logic                        cfg_we,
  input  wire logic [ndhs_pkg::TBL_AW-1:0] cfg_offset,
  output logic                             res_valid,
  output logic [ndhs_pkg::TBL_AW-1:0]      res_index,
  output logic                             res_new,
  output logic [1:0]                       res_status
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RED = 4'd2, S_RD_SLOT = 4'd3,
                         S_CHK_SLOT = 4'd4, S_CMP_RD = 4'd5, S_CMP_CHK = 4'd6,
                         S_CPY_RD = 4'd7, S_CPY_WR = 4'd8;
  localparam int AW = ndhs_pkg::TBL_AW;
  localparam logic [AW:0] TSZ = (AW+1)'(ndhs_pkg::TABLE_SIZE);

  logic [ndhs_pkg::EDGE_W-1:0] buf_mem [2*ndhs_pkg::NODE_EDGE_CAP];
  logic [AW-1:0]               tbl_mem [ndhs_pkg::TABLE_SIZE];
  logic [ndhs_pkg::EDGE_W-1:0] store_mem [ndhs_pkg::TABLE_SIZE];

  logic [3:0]                  state_r, state_nxt;
  logic [ndhs_pkg::HASH_W-1:0] x_r, x_nxt;
  logic [AW-1:0]               first_r, first_nxt, slot_r, slot_nxt, step_r, step_nxt;
  logic [AW-1:0]               entry_r, entry_nxt, used_r, used_nxt, clr_r;
  logic [ndhs_pkg::IDX_W-1:0]  i_r, i_nxt;
  logic [AW-1:0]               tbl_q_r;
  logic [ndhs_pkg::EDGE_W-1:0] store_q_r, buf_q_r;
  logic                        rv_r, rv_nxt, rn_r, rn_nxt;
  logic [AW-1:0]               ri_r, ri_nxt;
  logic [1:0]                  rs_r, rs_nxt;

  logic                        tbl_we, store_we;
  logic [AW-1:0]               tbl_wa, tbl_wd, store_wa;
  logic [ndhs_pkg::EDGE_W-1:0] store_wd;
  logic [AW:0]                 cmp_sum, slot_sum, step_sum, used_sum;
  logic [AW-1:0]               cmp_addr, base, slot_adv, step_adv;
  logic [AW-1:0]               red_fold_lo;
  logic [ndhs_pkg::HASH_W-1:0] red_fold;
  logic                        last_i;

  assign clearing = (state_r == S_CLR);
  assign base     = used_r + 1'b1;
  assign last_i   = ({1'b0, i_r} == job.count - 1'b1);
  assign cmp_sum  = {1'b0, entry_r} + (AW+1)'(i_r);
  assign cmp_addr = (cmp_sum >= TSZ) ? AW'(cmp_sum - TSZ) : cmp_sum[AW-1:0];
  assign slot_sum = {1'b0, slot_r} + {1'b0, step_r};
  assign slot_adv = (slot_sum >= TSZ) ? AW'(slot_sum - TSZ) : slot_sum[AW-1:0];
  assign step_sum = {1'b0, step_r} + (AW+1)'(ndhs_pkg::STEP_GROWTH);
  assign step_adv = (step_sum >= TSZ) ? AW'(step_sum - TSZ) : step_sum[AW-1:0];
  assign used_sum = {1'b0, used_r} + (AW+1)'(job.count);
  assign red_fold_lo = x_r[AW-1:0];
  // 2^12 mod 4093 is 3, so the high part folds in times three.
  assign red_fold = (ndhs_pkg::HASH_W)'({x_r[ndhs_pkg::HASH_W-1:AW], 1'b0})
                  + (ndhs_pkg::HASH_W)'(x_r[ndhs_pkg::HASH_W-1:AW])
                  + (ndhs_pkg::HASH_W)'(red_fold_lo);

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; first_nxt = first_r; slot_nxt = slot_r; step_nxt = step_r;
    entry_nxt = entry_r; used_nxt = used_r; i_nxt = i_r;
    rv_nxt = 1'b0; rn_nxt = rn_r; ri_nxt = ri_r; rs_nxt = rs_r;
    pop = 1'b0;
    tbl_we = 1'b0; tbl_wa = slot_r; tbl_wd = base;
    store_we = 1'b0; store_wa = AW'(base + AW'(i_r)); store_wd = buf_q_r;
    unique case (state_r)
      S_CLR: begin
        tbl_we = 1'b1; tbl_wa = clr_r; tbl_wd = '0;
        store_we = 1'b1; store_wa = clr_r; store_wd = '0;
        if (clr_r == AW'(ndhs_pkg::TABLE_SIZE - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (job_valid) begin
          x_nxt = job.hash;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (x_r[ndhs_pkg::HASH_W-1:AW] != '0) begin
          x_nxt = red_fold;
        end else if (x_r[AW:0] >= TSZ) begin
          x_nxt = x_r - ndhs_pkg::HASH_W'(ndhs_pkg::TABLE_SIZE);
        end else begin
          first_nxt = x_r[AW-1:0];
          slot_nxt  = x_r[AW-1:0];
          step_nxt  = AW'(ndhs_pkg::FIRST_STEP);
          state_nxt = S_RD_SLOT;
        end
      end
      S_RD_SLOT: state_nxt = S_CHK_SLOT;
      S_CHK_SLOT: begin
        i_nxt = '0;
        if (tbl_q_r != '0) begin
          entry_nxt = tbl_q_r;
          state_nxt = S_CMP_RD;
        end else if (used_sum >= TSZ - 1'b1) begin
          rv_nxt = 1'b1; ri_nxt = '0; rn_nxt = 1'b0; rs_nxt = ndhs_pkg::ST_STORE_FULL;
          pop = 1'b1; state_nxt = S_IDLE;
        end else begin
          tbl_we = 1'b1;
          state_nxt = S_CPY_RD;
        end
      end
      S_CMP_RD: state_nxt = S_CMP_CHK;
      S_CMP_CHK: begin
        if (store_q_r != buf_q_r) begin
          slot_nxt = slot_adv;
          step_nxt = step_adv;
          if (slot_adv == first_r) begin
            rv_nxt = 1'b1; ri_nxt = '0; rn_nxt = 1'b0; rs_nxt = ndhs_pkg::ST_TABLE_FULL;
            pop = 1'b1; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD_SLOT;
          end
        end else if (last_i) begin
          rv_nxt = 1'b1; ri_nxt = entry_r; rn_nxt = 1'b0; rs_nxt = ndhs_pkg::ST_OK;
          pop = 1'b1; state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_CMP_RD;
        end
      end
      S_CPY_RD: state_nxt = S_CPY_WR;
      S_CPY_WR: begin
        store_we = 1'b1;
        if (last_i) begin
          used_nxt = used_sum[AW-1:0];
          rv_nxt = 1'b1; ri_nxt = base; rn_nxt = 1'b1; rs_nxt = ndhs_pkg::ST_OK;
          pop = 1'b1; state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_CPY_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) used_nxt = cfg_offset;
  end

  // Memories, all written and read in clocked blocks.
  always_ff @(posedge clk) begin
    if (buf_wr.we) buf_mem[{buf_wr.bank, buf_wr.idx}] <= buf_wr.data;
    buf_q_r <= buf_mem[{job.bank, i_r}];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_q_r <= tbl_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    store_q_r <= store_mem[cmp_addr];
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; first_r <= first_nxt; slot_r <= slot_nxt; step_r <= step_nxt;
    entry_r <= entry_nxt; i_r <= i_nxt;
    ri_r <= ri_nxt; rn_r <= rn_nxt; rs_r <= rs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      used_r  <= AW'(ndhs_pkg::START_RESET);
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_r + 1'b1;
      used_r  <= used_nxt;
      rv_r    <= rv_nxt;
    end
  end

  assign res_valid  = rv_r;
  assign res_index  = ri_r;
  assign res_new    = rn_r;
  assign res_status = rs_r;

  a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r && rn_r |-> rs_r == ndhs_pkg::ST_OK) else $error("new node with bad status");
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> job_valid) else $error("pop from empty queue");
  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK_SLOT |-> $past(state_r) == S_RD_SLOT) else $error("slot check skipped read");
  a_result_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> rv_r) else $error("pop without result");
endmodule
`default_nettype wire

### src/node_dedup_hash_store_unit.sv
// Top level of the node dedup hash store: front end, node queue and back end.
//
// Channel   Ports                                         Handshake
// input     in_edge_word, in_last_edge                     start && !busy
// result    out_node_index, out_was_new, out_status        out_valid, one cycle
// config    cfg_start_offset                               cfg_valid && cfg_ready
//
// The front end writes up to 256 accepted edges of each node into the edge buffer.
// The request that closes a node queues it for the back end, which passes through
// its idle state, a step for each fold or subtraction of the hash reduction and
// a step to pick the first slot, then a read and a check state per slot probed
// and a read and a compare or write state per edge, on memories that each have
// one write port and one registered read port. The node being
// worked on stays in the queue while the front end collects the next one into the
// other buffer bank; busy rises when both banks hold queued nodes. After reset the
// slot table and edge store are swept to zero, all 4093 entries, one entry a
// cycle, with busy high. Results cannot be stalled.
`default_nettype none
module node_dedup_hash_store_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_edge_word,
  input  wire logic        in_last_edge,
  output logic             out_valid,
  output logic [11:0]      out_node_index,
  output logic             out_was_new,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_start_offset
);
  ndhs_pkg::buf_wr_t buf_wr;
  ndhs_pkg::job_t    push_job, head_job;
  logic              accept, push, pop, head_valid, q_full, clearing;

  // A request is taken whenever a buffer bank is free and the sweep is done.
  assign busy      = clearing || q_full;
  assign accept    = start && !busy;
  // The offset only touches the edge counter, so it is always writable.
  assign cfg_ready = 1'b1;

  ndhs_front u_front (
    .clk, .rst_n, .accept,
    .edge_word (in_edge_word),
    .last_edge (in_last_edge),
    .buf_wr, .push,
    .job       (push_job)
  );

  ndhs_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop,
    .head_valid, .head_job,
    .full      (q_full)
  );

  ndhs_back u_back (
    .clk, .rst_n, .buf_wr,
    .job_valid (head_valid),
    .job       (head_job),
    .pop, .clearing,
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_offset(cfg_start_offset),
    .res_valid (out_valid),
    .res_index (out_node_index),
    .res_new   (out_was_new),
    .res_status(out_status)
  );
endmodule
`default_nettype wire

### tb/sv/node_dedup_hash_store_unit_test.sv
// Self-checking testbench for the node dedup hash store: random and directed nodes.
`default_nettype none
module node_dedup_hash_store_unit_test;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // Block inputs, all known from time zero.
  logic        start = 1'b0;
  logic [31:0] in_edge_word = '0;
  logic        in_last_edge = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [11:0] cfg_start_offset = '0;
  logic        busy, out_valid, out_was_new, cfg_ready;
  logic [11:0] out_node_index;
  logic [1:0]  out_status;

  node_dedup_hash_store_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_edge_word(in_edge_word), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_node_index(out_node_index),
    .out_was_new(out_was_new), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_start_offset(cfg_start_offset)
  );

  // One edge request, and one lookup answer.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } edge_req_t;

  typedef struct packed {
    logic [11:0] index;
    logic        fresh;
    logic [1:0]  status;
  } lookup_ans_t;

  // Shadow copy of the store, kept by the predictor.
  logic [31:0] node_edges [ndhs_pkg::NODE_EDGE_CAP];
  int unsigned node_len;
  logic [31:0] fold_hash;
  logic [11:0] slot_ptr [ndhs_pkg::TABLE_SIZE];
  logic [31:0] store_mem [ndhs_pkg::TABLE_SIZE];
  int unsigned used_edges;

  edge_req_t   edge_queue[$];
  lookup_ans_t answer_queue[$];
  int unsigned fail_count = 0;
  longint unsigned cycle_count = 0;

  // Resets the predictor to the state the block wakes up in.
  function automatic void model_clear();
    for (int k = 0; k < ndhs_pkg::TABLE_SIZE; k++) begin
      slot_ptr[k] = '0;
      store_mem[k] = '0;
    end
    node_len = 0;
    fold_hash = '0;
    used_edges = ndhs_pkg::START_RESET;
  endfunction

  // Compares the buffered node against the stored node that starts at first.
  function automatic bit node_matches(int unsigned first);
    for (int unsigned k = 0; k < node_len; k++)
      if (store_mem[(first + k) % ndhs_pkg::TABLE_SIZE] != node_edges[k]) return 1'b0;
    return 1'b1;
  endfunction

  // Quadratic probe for the closed node, appending it when no twin is found.
  function automatic lookup_ans_t probe_node();
    lookup_ans_t ans;
    int unsigned home, slot, stride, base;
    home = fold_hash % ndhs_pkg::TABLE_SIZE;
    slot = home;
    stride = ndhs_pkg::FIRST_STEP;
    ans = '0;
    forever begin
      if (slot_ptr[slot] == 0) break;
      if (node_matches(slot_ptr[slot])) begin
        ans.index = slot_ptr[slot];
        ans.status = ndhs_pkg::ST_OK;
        return ans;
      end
      slot += stride;
      stride += ndhs_pkg::STEP_GROWTH;
      if (slot >= ndhs_pkg::TABLE_SIZE) slot -= ndhs_pkg::TABLE_SIZE;
      if (stride >= ndhs_pkg::TABLE_SIZE) stride -= ndhs_pkg::TABLE_SIZE;
      if (slot == home) begin
        ans.status = ndhs_pkg::ST_TABLE_FULL;
        return ans;
      end
    end
    if (used_edges + node_len >= ndhs_pkg::TABLE_SIZE - 1) begin
      ans.status = ndhs_pkg::ST_STORE_FULL;
      return ans;
    end
    base = used_edges + 1;
    slot_ptr[slot] = base[11:0];
    for (int unsigned k = 0; k < node_len; k++)
      store_mem[(base + k) % ndhs_pkg::TABLE_SIZE] = node_edges[k];
    used_edges += node_len;
    ans.index = base[11:0];
    ans.fresh = 1'b1;
    ans.status = ndhs_pkg::ST_OK;
    return ans;
  endfunction

  // Folds one accepted edge into the predictor and queues an answer on a last edge.
  function automatic void absorb_edge(edge_req_t req);
    if (node_len < ndhs_pkg::NODE_EDGE_CAP) begin
      node_edges[node_len] = req.word;
      node_len++;
      fold_hash = {fold_hash[30:0], fold_hash[31]} ^ req.word;
    end
    if (req.last) begin
      answer_queue.push_back(probe_node());
      node_len = 0;
      fold_hash = '0;
    end
  endfunction

  // Short gaps mostly, long ones now and then, and none at all in bursts.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: presents edge requests from the queue. A request is taken at an edge
  // where start is high and busy is low; start then either stays high for the next
  // request or drops for a gap, with a single assignment per edge.
  int unsigned idle_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && !busy) begin
        absorb_edge('{word: in_edge_word, last: in_last_edge});
        idle_left = pick_gap();
        if (idle_left == 0 && edge_queue.size() > 0) begin
          {in_edge_word, in_last_edge} <= edge_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (edge_queue.size() > 0) begin
          {in_edge_word, in_last_edge} <= edge_queue.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: every out_valid cycle carries one answer that must match the oldest
  // prediction field by field.
  always @(posedge clk) begin
    lookup_ans_t want;
    if (rst_n && out_valid) begin
      if (answer_queue.size() == 0) begin
        $display("%0t: unexpected result index=%0d new=%0d status=%0d",
                 $time, out_node_index, out_was_new, out_status);
        fail_count++;
      end else begin
        want = answer_queue.pop_front();
        if (out_node_index !== want.index) begin
          $display("%0t: node_index expected %0d actual %0d", $time, want.index, out_node_index);
          fail_count++;
        end
        if (out_was_new !== want.fresh) begin
          $display("%0t: was_new expected %0d actual %0d", $time, want.fresh, out_was_new);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // Timeout guard. The bound covers the reset sweep plus every node waiting out
  // the worst gap and probe work, with wide margin.
  always @(posedge clk) begin
    if (cycle_count > 64'd900000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Remembered nodes, replayed later so that lookups hit stored twins.
  logic [31:0] saved_nodes[$][$];

  // Queues one node of the given edges, recording it for later replay if it fits the buffer.
  task automatic queue_node(input logic [31:0] words[$]);
    for (int k = 0; k < words.size(); k++)
      edge_queue.push_back('{word: words[k], last: (k == words.size() - 1)});
    if (words.size() <= ndhs_pkg::NODE_EDGE_CAP) saved_nodes.push_back(words);
  endtask

  // Random node: mostly short, rarely long, sometimes past the buffer size.
  task automatic random_node();
    logic [31:0] words[$];
    int unsigned len, r;
    r = $urandom_range(99);
    if (r < 85) len = $urandom_range(4, 1);
    else if (r < 98) len = $urandom_range(20, 5);
    else len = $urandom_range(ndhs_pkg::NODE_EDGE_CAP + 4, ndhs_pkg::NODE_EDGE_CAP - 2);
    for (int unsigned k = 0; k < len; k++)
      words.push_back(($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom);
    queue_node(words);
  endtask

  // Waits until the queue is drained and all answers have arrived, then lets the
  // back end settle.
  task automatic drain_block();
    while (edge_queue.size() > 0 || start || answer_queue.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Writes the start offset register; only done while the block is idle.
  task automatic write_offset(input logic [11:0] value);
    cfg_start_offset <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    used_edges = value;
  endtask

  int unsigned edges_sent;
  logic [11:0] offsets[4];
  initial begin
    logic [31:0] w[$];
    model_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of the edge word, a repeated node, single-edge nodes
    // with all-zero and all-one words, and a node longer than the buffer.
    w = '{32'h0}; queue_node(w);
    w = '{32'hFFFF_FFFF}; queue_node(w);
    w = '{32'h0}; queue_node(w);
    w = '{32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_0001}; queue_node(w);
    w = '{32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_0001}; queue_node(w);
    w = '{32'h1, 32'h2}; queue_node(w);
    w = '{32'h2, 32'h4}; queue_node(w);
    w = {};
    for (int k = 0; k < ndhs_pkg::NODE_EDGE_CAP + 3; k++) w.push_back(32'(k * 7));
    queue_node(w);
    drain_block();

    // Phases through several offsets, the extremes among them. The largest offset
    // makes every new node report the store full while lookups still hit.
    offsets = '{12'd0, 12'd4092, 12'd4080, 12'd2000};
    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_offset(offsets[p - 1]);
      edges_sent = 0;
      while (edges_sent < 290) begin
        if (saved_nodes.size() > 0 && $urandom_range(3) == 0)
          queue_node(saved_nodes[$urandom_range(saved_nodes.size() - 1)]);
        else
          random_node();
        edges_sent = edge_queue.size();
      end
      drain_block();
    end

    if (fail_count == 0 && answer_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
